// File: src/gps_binary_frame_validator_unit_macros.svh
// Assertion macros for the binary frame validator.
// Needs nothing else; included by files that carry concurrent checks.
`ifndef GPS_BINARY_FRAME_VALIDATOR_UNIT_MACROS_SVH
`define GPS_BINARY_FRAME_VALIDATOR_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// property holds at every clock edge outside reset
`define GBFV_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("gbfv check failed");
// condition never true outside reset
`define GBFV_ASSERT_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("gbfv forbidden condition seen");
`else
`define GBFV_ASSERT(lbl, clk, rstn, prop)
`define GBFV_ASSERT_NEVER(lbl, clk, rstn, cond)
`endif
`endif

// File: src/gbfv_pkg.sv
// Shared types and constants for the binary frame validator.
// No dependencies; imported by the interfaces and all modules.
package gbfv_pkg;

  localparam int unsigned PosWidth  = 17;
  localparam int unsigned LenWidth  = 16;
  localparam int unsigned SumWidth  = 15;
  localparam int unsigned AddrWidth = 3;
  localparam int unsigned DataWidth = 32;

  localparam logic [7:0] Start1 = 8'hA0;
  localparam logic [7:0] Start2 = 8'hA2;
  localparam logic [7:0] End1   = 8'hB0;
  localparam logic [7:0] End2   = 8'hB3;
  localparam logic [PosWidth-1:0] Overhead = 17'd8;
  localparam logic [LenWidth-1:0] MaxLenReset = 16'd1023;

  // register byte addresses
  localparam logic [AddrWidth-1:0] AddrMaxPayload = 3'd0;

  typedef enum logic [1:0] {
    VERDICT_VALID     = 2'd0,
    VERDICT_NOT_FRAME = 2'd1,
    VERDICT_TRUNCATED = 2'd2
  } verdict_e;

  typedef struct packed {
    logic [7:0]          data_byte;
    logic                first_byte;
    logic [PosWidth-1:0] buffer_length;
  } in_item_t;

  typedef struct packed {
    logic                valid;
    verdict_e            verdict;
    logic [PosWidth-1:0] frame_length;
  } result_t;

endpackage

// File: src/gbfv_if.sv
// Valid/ready channel interfaces for input bytes and verdicts.
// Depends on gbfv_pkg.
interface gbfv_in_if import gbfv_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [7:0]          data_byte;
  logic                first_byte;
  logic [PosWidth-1:0] buffer_length;

  modport source (output valid, data_byte, first_byte, buffer_length, input ready);
  modport sink   (input valid, data_byte, first_byte, buffer_length, output ready);
endinterface

interface gbfv_out_if import gbfv_pkg::*; ();
  logic                valid;
  logic                ready;
  verdict_e            verdict;
  logic [PosWidth-1:0] frame_length;

  modport source (output valid, verdict, frame_length, input ready);
  modport sink   (input valid, verdict, frame_length, output ready);
endinterface

// File: src/gbfv_core.sv
// Frame checking state and per-byte decision logic.
// Depends on gbfv_pkg.
module gbfv_core import gbfv_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  in_item_t            item_i,
  input  logic [LenWidth-1:0] max_len_i,
  output result_t             res_o
);

  logic [PosWidth-1:0] pos_q, pos_d;
  logic [LenWidth-1:0] decl_q, decl_d;
  logic [SumWidth-1:0] run_q, run_d;
  logic [LenWidth-1:0] rx_q, rx_d;
  logic [PosWidth-1:0] avail_q, avail_d;
  logic                done_q, done_d;

  logic [PosWidth-1:0] pos_e, avail_e, rel, decl17, decl_new17;
  logic [LenWidth-1:0] decl_e, rx_e, decl_new;
  logic [SumWidth-1:0] run_e;
  logic                done_e;
  logic [7:0]          b;

  always_comb begin
    b        = item_i.data_byte;
    // a first byte restarts checking before anything else
    done_e   = item_i.first_byte ? 1'b0 : done_q;
    pos_e    = item_i.first_byte ? '0 : pos_q;
    decl_e   = item_i.first_byte ? '0 : decl_q;
    run_e    = item_i.first_byte ? '0 : run_q;
    rx_e     = item_i.first_byte ? '0 : rx_q;
    avail_e  = item_i.first_byte ? item_i.buffer_length : avail_q;
    rel      = pos_e - 17'd4;
    decl17   = {1'b0, decl_e};
    decl_new = {decl_e[15:8], b};
    decl_new17 = {1'b0, decl_new};

    pos_d   = pos_q;
    decl_d  = decl_q;
    run_d   = run_q;
    rx_d    = rx_q;
    avail_d = avail_q;
    done_d  = done_q;
    res_o   = '{valid: 1'b0, verdict: VERDICT_VALID, frame_length: '0};

    if (step_i) begin
      decl_d  = decl_e;
      run_d   = run_e;
      rx_d    = rx_e;
      avail_d = avail_e;
      done_d  = done_e;
      pos_d   = pos_e;
      if (!done_e) begin
        pos_d = pos_e + 17'd1;
        if (pos_e == 17'd0) begin
          if (b != Start1) begin
            res_o.valid = 1'b1;
            res_o.verdict = VERDICT_NOT_FRAME;
          end else if (avail_e < Overhead) begin
            res_o.valid = 1'b1;
            res_o.verdict = VERDICT_TRUNCATED;
          end
        end else if (pos_e == 17'd1) begin
          if (b != Start2) begin
            res_o.valid = 1'b1;
            res_o.verdict = VERDICT_NOT_FRAME;
          end
        end else if (pos_e == 17'd2) begin
          decl_d = {b, 8'h00};
        end else if (pos_e == 17'd3) begin
          decl_d = decl_new;
          if (decl_new > max_len_i) begin
            res_o.valid = 1'b1;
            res_o.verdict = VERDICT_NOT_FRAME;
          end else if (avail_e < decl_new17 + Overhead) begin
            res_o.valid = 1'b1;
            res_o.verdict = VERDICT_TRUNCATED;
          end
        end else if (rel < decl17) begin
          run_d = run_e + {7'd0, b};
        end else if (rel == decl17) begin
          rx_d = {b, 8'h00};
        end else if (rel == decl17 + 17'd1) begin
          rx_d = {rx_e[15:8], b};
        end else if (rel == decl17 + 17'd2) begin
          if (b != End1) begin
            res_o.valid = 1'b1;
            res_o.verdict = VERDICT_NOT_FRAME;
          end
        end else begin
          res_o.valid = 1'b1;
          // checksum with bit 15 set can never match the 15-bit sum
          if (b != End2 || rx_e != {1'b0, run_e}) begin
            res_o.verdict = VERDICT_NOT_FRAME;
          end else begin
            res_o.verdict = VERDICT_VALID;
            res_o.frame_length = decl17 + Overhead;
          end
        end
        if (res_o.valid) begin
          done_d = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      decl_q  <= '0;
      run_q   <= '0;
      rx_q    <= '0;
      avail_q <= '0;
      done_q  <= 1'b1;
    end else begin
      pos_q   <= pos_d;
      decl_q  <= decl_d;
      run_q   <= run_d;
      rx_q    <= rx_d;
      avail_q <= avail_d;
      done_q  <= done_d;
    end
  end

endmodule

// File: src/gps_binary_frame_validator_unit.sv
// Binary GPS frame validator, top level.
// Depends on gbfv_pkg, gbfv_if, gbfv_core and the assertion macro header.
//
// Usage:
//  - in_i carries one buffer byte per item, with first_byte set on the first
//    byte of each candidate buffer and the buffer's available length alongside.
//  - out_o carries at most one verdict per buffer: valid (with frame length),
//    not a frame, or truncated. Bytes after the verdict are dropped silently;
//    a new first byte before a verdict abandons the old buffer.
//  - APB port: max_payload_length at byte address 0 (reset 1023). Write only
//    while no byte is in flight.
// Timing:
//  - One byte per cycle sustained unless a held verdict is not taken. A byte
//    sits in the input register, is checked there and any verdict lands
//    in the result register, which drives out_o.
//  - The result register decouples the two sides: one new byte is accepted
//    into an empty input register while a verdict waits to be taken.
// Reset: all control cleared, block idles (verdict given) until a first byte.
// Stall: when out_o.ready is low and a verdict is held, the input register
//  holds its byte and in_i.ready drops once it is full.
`include "gps_binary_frame_validator_unit_macros.svh"

module gps_binary_frame_validator_unit import gbfv_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  gbfv_in_if.sink              in_i,
  gbfv_out_if.source           out_o,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [AddrWidth-1:0] paddr,
  input  logic [DataWidth-1:0] pwdata,
  output logic [DataWidth-1:0] prdata,
  output logic                 pready
);

  // configuration
  logic [LenWidth-1:0] max_len_q;

  assign pready = 1'b1;
  assign prdata = (paddr == AddrMaxPayload) ? {16'd0, max_len_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= MaxLenReset;
    end else if (psel && penable && pwrite && paddr == AddrMaxPayload) begin
      max_len_q <= pwdata[LenWidth-1:0];
    end
  end

  // input register
  in_item_t s1_q;
  logic     s1_valid_q;
  logic     out_free;
  logic     s1_fire;
  logic     in_fire;

  // result register
  logic                out_valid_q;
  verdict_e            verdict_q;
  logic [PosWidth-1:0] frame_len_q;

  result_t res;

  assign out_free    = !out_valid_q || out_o.ready;
  assign s1_fire     = s1_valid_q && out_free;
  assign in_i.ready  = !s1_valid_q || s1_fire;
  assign in_fire     = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_q <= '{data_byte: in_i.data_byte, first_byte: in_i.first_byte,
                buffer_length: in_i.buffer_length};
    end
  end

  gbfv_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (s1_fire),
    .item_i    (s1_q),
    .max_len_i (max_len_q),
    .res_o     (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= res.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && res.valid) begin
      verdict_q   <= res.verdict;
      frame_len_q <= res.frame_length;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.verdict      = verdict_q;
  assign out_o.frame_length = frame_len_q;

  // checks
  `GBFV_ASSERT(a_valid_len_min, clk_i, rst_ni,
    (out_valid_q && verdict_q == VERDICT_VALID) |-> (frame_len_q >= Overhead))
  `GBFV_ASSERT(a_reject_len_zero, clk_i, rst_ni,
    (out_valid_q && verdict_q != VERDICT_VALID) |-> (frame_len_q == '0))
  `GBFV_ASSERT(a_byte_held_on_stall, clk_i, rst_ni,
    (s1_valid_q && !out_free) |=> s1_valid_q)
  `GBFV_ASSERT_NEVER(a_ready_when_empty, clk_i, rst_ni,
    !s1_valid_q && !in_i.ready)

endmodule

// File: tb/gbfv_verdict_tracker.sv
// Verdict tracker for the binary frame validator: predicts and checks verdicts.
// Depends on gbfv_pkg and the channel interfaces in gbfv_if.
// Watches both channels and the APB writes, and reports its fault count to the bench.
module gbfv_verdict_tracker import gbfv_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  gbfv_in_if                   in_mon,
  gbfv_out_if                  out_mon,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [AddrWidth-1:0] paddr,
  input  logic [DataWidth-1:0] pwdata,
  input  logic                 pready,
  output int unsigned          fault_count,
  output int unsigned          verdicts_owed
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    verdict_e            verdict;
    logic [PosWidth-1:0] frame_length;
  } verdict_item_t;

  verdict_item_t owed_q[$];

  // shadow of the block's register and scan state
  logic [LenWidth-1:0] max_len;
  logic [PosWidth-1:0] byte_pos;
  logic [PosWidth-1:0] avail_len;
  logic [LenWidth-1:0] decl_len;
  logic [LenWidth-1:0] sent_sum;
  logic [SumWidth-1:0] payload_sum;
  logic                settled;

  // Advances the scan by one byte; returns 1 when this byte settles the buffer.
  function automatic bit scan_byte(input logic [7:0] b, input logic first,
                                   input logic [PosWidth-1:0] len,
                                   output verdict_item_t res);
    logic [PosWidth-1:0] pos;
    int unsigned         off;
    bit                  hit;
    res.verdict      = VERDICT_NOT_FRAME;
    res.frame_length = '0;
    hit              = 1'b0;
    if (first) begin
      settled     = 1'b0;
      byte_pos    = '0;
      decl_len    = '0;
      payload_sum = '0;
      sent_sum    = '0;
      avail_len   = len;
    end
    if (settled) return 1'b0;
    pos      = byte_pos;
    byte_pos = byte_pos + 1'b1;
    if (pos == 0) begin
      if (b != Start1) begin
        hit = 1'b1;
      end else if (avail_len < Overhead) begin
        hit         = 1'b1;
        res.verdict = VERDICT_TRUNCATED;
      end
    end else if (pos == 1) begin
      hit = (b != Start2);
    end else if (pos == 2) begin
      decl_len = {b, 8'h00};
    end else if (pos == 3) begin
      decl_len[7:0] = b;
      if (decl_len > max_len) begin
        hit = 1'b1;
      end else if (avail_len < {1'b0, decl_len} + Overhead) begin
        hit         = 1'b1;
        res.verdict = VERDICT_TRUNCATED;
      end
    end else begin
      off = pos - 4;
      if (off < decl_len) begin
        payload_sum = payload_sum + b;
      end else if (off == decl_len) begin
        sent_sum = {b, 8'h00};
      end else if (off == decl_len + 1) begin
        sent_sum[7:0] = b;
      end else if (off == decl_len + 2) begin
        hit = (b != End1);
      end else begin
        hit = 1'b1;
        // a sent sum with its top bit set can never match the 15-bit sum
        if (b == End2 && sent_sum == {1'b0, payload_sum}) begin
          res.verdict      = VERDICT_VALID;
          res.frame_length = {1'b0, decl_len} + Overhead;
        end
      end
    end
    if (hit) settled = 1'b1;
    return hit;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    verdict_item_t want;
    int unsigned   errs;
    if (!rst_ni) begin
      owed_q.delete();
      max_len       = MaxLenReset;
      byte_pos      = '0;
      avail_len     = '0;
      decl_len      = '0;
      sent_sum      = '0;
      payload_sum   = '0;
      settled       = 1'b1;
      fault_count   <= 0;
      verdicts_owed <= 0;
    end else begin
      errs = 0;
      if (out_mon.valid && out_mon.ready) begin
        if (owed_q.size() == 0) begin
          $display("%0t: verdict %0d length %0d with none owed", $time,
                   out_mon.verdict, out_mon.frame_length);
          errs++;
        end else begin
          want = owed_q.pop_front();
          if (out_mon.verdict !== want.verdict) begin
            $display("%0t: verdict expected %0d actual %0d", $time,
                     want.verdict, out_mon.verdict);
            errs++;
          end
          if (out_mon.frame_length !== want.frame_length) begin
            $display("%0t: frame_length expected %0d actual %0d", $time,
                     want.frame_length, out_mon.frame_length);
            errs++;
          end
        end
      end
      if (psel && penable && pwrite && pready && paddr == AddrMaxPayload)
        max_len = pwdata[LenWidth-1:0];
      if (in_mon.valid && in_mon.ready) begin
        if (scan_byte(in_mon.data_byte, in_mon.first_byte, in_mon.buffer_length, want))
          owed_q.push_back(want);
      end
      fault_count   <= fault_count + errs;
      verdicts_owed <= owed_q.size();
    end
  end

endmodule

// File: tb/gps_binary_frame_validator_unit_test.sv
// Bench top for the binary frame validator: clock, reset, byte stimulus and verdict.
// Depends on gbfv_pkg, gbfv_if, the validator RTL and gbfv_verdict_tracker.
// Directed buffers per phase, then random frames, broken frames and line noise.
module gps_binary_frame_validator_unit_test import gbfv_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  // how a generated frame is spoilt, if at all
  typedef enum int {
    FR_GOOD,
    FR_BAD_START1,
    FR_BAD_START2,
    FR_BAD_SUM,
    FR_SUM_TOP_BIT,
    FR_BAD_END1,
    FR_BAD_END2
  } frame_kind_e;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [AddrWidth-1:0] paddr;
  logic [DataWidth-1:0] pwdata;
  logic [DataWidth-1:0] prdata;
  logic                 pready;
  int unsigned          fault_count;
  int unsigned          verdicts_owed;

  // idle odds in percent for each side, changed per phase
  int unsigned          snd_idle_pct;
  int unsigned          rcv_idle_pct;
  // bench copy of max_payload_length, only used to shape the frames
  logic [LenWidth-1:0]  max_cfg;
  // bytes of the buffer being built
  logic [7:0]           buf_q[$];

  gbfv_in_if  in_ch ();
  gbfv_out_if out_ch ();

  gps_binary_frame_validator_unit u_top (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_ch),
    .out_o   (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  gbfv_verdict_tracker u_verdict_tracker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_mon        (in_ch),
    .out_mon       (out_ch),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .pready        (pready),
    .fault_count   (fault_count),
    .verdicts_owed (verdicts_owed)
  );

  always #4 clk_i = ~clk_i;

  // Receiver: ready drawn afresh every cycle at the phase's idle odds.
  always @(posedge clk_i) begin
    out_ch.ready <= ($urandom_range(99) >= rcv_idle_pct);
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #3_000_000;
    $display("gps_binary_frame_validator_unit_test: errors");
    $finish;
  end

  // One byte onto the input channel. Valid is only dropped during a random gap,
  // so back-to-back items keep it high with a single assignment per edge.
  task automatic push_byte(input logic [7:0] value, input logic first,
                           input logic [PosWidth-1:0] avail);
    while ($urandom_range(99) < snd_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid         <= 1'b1;
    in_ch.data_byte     <= value;
    in_ch.first_byte    <= first;
    in_ch.buffer_length <= avail;
    do @(posedge clk_i); while (!in_ch.ready);
  endtask

  // Sends buf_q as one buffer. With jitter the later bytes carry a random
  // length, which the block must ignore - only the first byte's counts.
  task automatic send_buffer(input logic [PosWidth-1:0] avail, input bit jitter);
    for (int i = 0; i < buf_q.size(); i++)
      push_byte(buf_q[i], i == 0,
                (i != 0 && jitter) ? PosWidth'($urandom_range(0, 65543)) : avail);
  endtask

  // Stops sending and waits for every owed verdict, then waits on in
  // case the last byte is still in the pipe without causing a verdict.
  // The first edge lets the tracker count the last accepted byte.
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (verdicts_owed != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // APB write: setup cycle, then access cycle until pready. Upper data bits
  // are random; the register is 16 bits wide.
  task automatic write_max_payload(input logic [LenWidth-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= AddrMaxPayload;
    pwdata  <= {16'($urandom), value};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    max_cfg = value;
  endtask

  function automatic logic [7:0] other_than(input logic [7:0] v);
    logic [7:0] r;
    r = 8'($urandom);
    if (r == v) r = ~v;
    return r;
  endfunction

  // Builds a whole frame into buf_q with a correct 15-bit sum, then spoils it
  // as asked. All-FF payloads push the sum past its wrap quickly.
  function automatic void build_frame(input int unsigned plen, input frame_kind_e kind,
                                      input bit all_ff);
    logic [7:0]          b;
    logic [SumWidth-1:0] sum;
    logic [15:0]         cks;
    sum   = '0;
    buf_q = {(kind == FR_BAD_START1) ? other_than(Start1) : Start1,
             (kind == FR_BAD_START2) ? other_than(Start2) : Start2,
             8'(plen >> 8), 8'(plen)};
    for (int unsigned i = 0; i < plen; i++) begin
      b   = all_ff ? 8'hFF : 8'($urandom);
      sum = sum + b;
      buf_q.push_back(b);
    end
    cks = {1'b0, sum};
    if (kind == FR_BAD_SUM) cks[SumWidth-1:0] = sum ^ SumWidth'($urandom_range(1, 32767));
    if (kind == FR_SUM_TOP_BIT) cks[15] = 1'b1;
    buf_q.push_back(cks[15:8]);
    buf_q.push_back(cks[7:0]);
    buf_q.push_back((kind == FR_BAD_END1) ? other_than(End1) : End1);
    buf_q.push_back((kind == FR_BAD_END2) ? other_than(End2) : End2);
  endfunction

  // One random buffer. Mostly well-formed frames with random payloads so the
  // checksum and end-byte states are reached; the rest is noise, declared
  // lengths over the limit, spoilt frames, short buffers and buffers cut off early.
  // counted excludes trailing bytes that follow a verdict.
  task automatic random_buffer(output int unsigned counted);
    int unsigned         pick;
    int unsigned         plen;
    frame_kind_e         kind;
    logic [PosWidth-1:0] avail;
    bit                  jitter;
    pick   = $urandom_range(99);
    jitter = ($urandom_range(9) == 0);
    if (pick < 12) begin
      // line noise, with A0 now and then so the length check is hit
      buf_q = {};
      repeat ($urandom_range(1, 6)) buf_q.push_back(8'($urandom));
      if ($urandom_range(3) == 0) buf_q[0] = Start1;
      avail = PosWidth'($urandom_range(0, 65543));
    end else if (pick < 20 && max_cfg != 16'hFFFF) begin
      // declared length above the register: rejected on the fourth byte
      plen  = $urandom_range(int'(max_cfg) + 1, 65535);
      buf_q = {Start1, Start2, 8'(plen >> 8), 8'(plen)};
      avail = PosWidth'($urandom_range(0, 65543));
    end else begin
      pick = $urandom_range(99);
      if (pick < 70) plen = $urandom_range(0, 16);
      else if (pick < 95) plen = $urandom_range(17, 80);
      else plen = $urandom_range(81, 300);
      if (plen > max_cfg) plen = max_cfg;
      kind = ($urandom_range(99) < 65) ? FR_GOOD
           : frame_kind_e'($urandom_range(FR_BAD_START1, FR_BAD_END2));
      build_frame(plen, kind, $urandom_range(19) == 0);
      pick = $urandom_range(99);
      if (pick < 12) begin
        // too few bytes available: verdict on or before the fourth byte
        avail = PosWidth'($urandom_range(0, plen + 7));
        plen  = $urandom_range(4, 6);
        while (buf_q.size() > plen) void'(buf_q.pop_back());
      end else begin
        if ($urandom_range(19) == 0) avail = PosWidth'($urandom_range(plen + 8, 65543));
        else avail = PosWidth'(plen + 8 + $urandom_range(0, 3));
        if (pick < 20) begin
          // buffer cut off: the next first byte abandons it
          plen = $urandom_range(1, buf_q.size() - 1);
          while (buf_q.size() > plen) void'(buf_q.pop_back());
        end
      end
    end
    counted = buf_q.size();
    if ($urandom_range(3) == 0)
      repeat ($urandom_range(1, 3)) buf_q.push_back(8'($urandom));
    send_buffer(avail, jitter);
  endtask

  // Random buffers until about goal bytes have gone out; now and then the
  // sender holds off until every verdict is back.
  task automatic random_run(input int unsigned goal);
    int unsigned sent;
    int unsigned n;
    sent = 0;
    while (sent < goal) begin
      random_buffer(n);
      sent += n;
      if ($urandom_range(39) == 0) drain();
    end
  endtask

  initial begin
    rst_ni              = 1'b0;
    in_ch.valid         = 1'b0;
    in_ch.data_byte     = '0;
    in_ch.first_byte    = 1'b0;
    in_ch.buffer_length = '0;
    out_ch.ready        = 1'b0;
    psel                = 1'b0;
    penable             = 1'b0;
    pwrite              = 1'b0;
    paddr               = '0;
    pwdata              = '0;
    max_cfg             = MaxLenReset;
    snd_idle_pct        = 24;
    rcv_idle_pct        = 62;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Phase 1: register at its reset value, sender idles less than receiver.
    // Bytes with no first marker straight after reset are dropped.
    push_byte(8'h00, 1'b0, PosWidth'(0));
    push_byte(8'hFF, 1'b0, PosWidth'(65543));
    buf_q = {8'h00};
    send_buffer(PosWidth'(8), 1'b0);
    // zero and seven bytes available: truncated on the start byte
    buf_q = {Start1};
    send_buffer(PosWidth'(0), 1'b0);
    buf_q = {Start1};
    send_buffer(PosWidth'(7), 1'b0);
    buf_q = {Start1, 8'h00};
    send_buffer(PosWidth'(8), 1'b0);
    // declared 1024 against the reset limit of 1023
    buf_q = {Start1, Start2, 8'h04, 8'h00};
    send_buffer(PosWidth'(65543), 1'b0);
    // five payload bytes declared, only twelve available
    buf_q = {Start1, Start2, 8'h00, 8'h05};
    send_buffer(PosWidth'(12), 1'b0);
    // checksum with its top bit set never matches
    buf_q = {Start1, Start2, 8'h00, 8'h01, 8'h10, 8'h80, 8'h10, End1, End2};
    send_buffer(PosWidth'(9), 1'b0);
    random_run(420);
    drain();

    // Phase 2: limit at zero, idle odds swapped.
    snd_idle_pct = 62;
    rcv_idle_pct = 24;
    write_max_payload(16'h0000);
    buf_q = {Start1, Start2, 8'h00, 8'h01};
    send_buffer(PosWidth'(9), 1'b0);
    buf_q = {Start1, Start2, 8'h00, 8'h00, 8'h00, 8'h00, End1, End2};
    send_buffer(PosWidth'(8), 1'b0);
    random_run(420);
    drain();

    // Phase 3: no idling; limit at its top, then a random middle value.
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    write_max_payload(16'hFFFF);
    // longest legal declaration, abandoned by the next buffer's first byte
    buf_q = {Start1, Start2, 8'hFF, 8'hFF, 8'h01, 8'h02};
    send_buffer(PosWidth'(65543), 1'b0);
    buf_q = {Start1, Start2, 8'h00, 8'h01, 8'h7F, 8'h00, 8'h7F, End1, End2};
    send_buffer(PosWidth'(9), 1'b1);
    random_run(220);
    drain();
    write_max_payload(LenWidth'($urandom_range(1, 300)));
    random_run(220);
    drain();
    repeat (8) @(posedge clk_i);

    if (fault_count == 0) begin
      $display("gps_binary_frame_validator_unit_test: clean");
    end else begin
      $display("gps_binary_frame_validator_unit_test: errors");
    end
    $finish;
  end

endmodule
